// ===== hw/rtl/keyframe_window_frame_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// keyframe window frame buffer assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_WINDOW_FRAME_BUFFER_ASSERT_SVH
`define KEYFRAME_WINDOW_FRAME_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KWFB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwfb assertion failed");

// next-cycle implication
`define KWFB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwfb assertion failed");

`else

`define KWFB_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define KWFB_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/kwfb_pkg.sv =====
// ----------------------------------------------------------------------------
// kwfb_pkg
// shared widths, word types, slot layout and state codes of the frame buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwfb_pkg;

  // ring geometry
  localparam int RING_DEPTH = 256;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // field widths
  localparam int HANDLE_W = 16;
  localparam int STAMP_W  = 48;
  localparam int DIFF_W   = STAMP_W + 1;
  localparam int LIMIT_W  = 40;
  localparam int COUNT_W  = 9;
  localparam int FLAG_W   = 2;

  // slot flag bits
  localparam int FLAG_KEY  = 0;
  localparam int FLAG_MARK = 1;

  // limits below this bound count keyframes, others are durations
  localparam logic [LIMIT_W-1:0] COUNT_MODE_BOUND = LIMIT_W'(10000);

  // register port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_IDX_LSB = 3;
  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_WINDOW_LIMIT = '0;

  // input word
  typedef struct packed {
    logic [HANDLE_W-1:0]       frame_handle;
    logic signed [STAMP_W-1:0] decode_stamp;
    logic                      is_keyframe;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                accepted;
    logic                ring_full;
    logic [COUNT_W-1:0]  dropped_count;
    logic                marked_valid;
    logic [HANDLE_W-1:0] marked_handle;
    logic [HANDLE_W-1:0] head_handle;
    logic [COUNT_W-1:0]  frames_held;
    logic [COUNT_W-1:0]  keyframes_held;
  } out_word_t;

  // one ring slot as stored in memory
  typedef struct packed {
    logic [HANDLE_W-1:0]       handle;
    logic signed [STAMP_W-1:0] stamp;
    logic [FLAG_W-1:0]         flags;
  } slot_t;

  // engine sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DONE
  } eng_state_t;

endpackage

// ===== hw/rtl/keyframe_window_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// keyframe_window_frame_buffer
// ring of frame descriptors trimmed to a keyframe window
//
// usage
//   in_*  : one frame descriptor per word (valid/stall). The word is taken at
//           a clock edge with in_valid high and in_stall low.
//   out_* : one result word per input word, same order, held in an output
//           register until out_stall is low.
//   cfg_* : register port, window_limit at byte address 0. Write it only
//           while no word is in flight.
//   order: a word without trimming passes the check and done states and
//           then the output register; a trim adds a read state and an
//           evaluate state for each ring slot walked from the head up to
//           and including the marked keyframe.
//   pacing: one word at a time; take, the check on the registered head
//           read, any trim walk and the result handoff set the pace.
//   stall: a held result does not block the next input word; the engine
//           waits only when it finishes a word while the output register is
//           still full.
//   reset: ring empty, window_limit zero (block disabled), no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyframe_window_frame_buffer_assert.svh"

module keyframe_window_frame_buffer
  import kwfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [LIMIT_W-1:0] window_limit;
  logic               res_valid;
  logic               res_ready;
  out_word_t          res;

  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  kwfb_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .window_limit (window_limit)
  );

  kwfb_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .window_limit (window_limit),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one word in flight at a time
  `KWFB_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
  // a finished result lands in the output register unchanged
  `KWFB_ASSERT_NXT(a_res_lands, clk, rst_n, res_valid && res_ready,
                   out_valid && (out_data == $past(res)))
  // a marked keyframe is counted in the held totals
  `KWFB_ASSERT_IMP(a_mark_counted, clk, rst_n, res_valid && res.marked_valid,
                   (res.keyframes_held != '0) && (res.frames_held >= res.keyframes_held))

endmodule

// ===== hw/rtl/kwfb_ram.sv =====
// ----------------------------------------------------------------------------
// kwfb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/kwfb_cfg.sv =====
// ----------------------------------------------------------------------------
// kwfb_cfg
// register port holding the window limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwfb_cfg
  import kwfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [LIMIT_W-1:0]    window_limit
);

  logic [LIMIT_W-1:0]                  limit_r;
  logic [LIMIT_W-1:0]                  limit_nxt;
  logic [CFG_ADDR_W-CFG_IDX_LSB-1:0]   reg_idx;
  logic                                wr_hit;

  assign reg_idx = cfg_paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign wr_hit  = cfg_psel && cfg_penable && cfg_pwrite;

  // register write decode
  always_comb begin
    limit_nxt = limit_r;
    if (wr_hit) begin
      unique case (reg_idx)
        REG_WINDOW_LIMIT: limit_nxt = cfg_pwdata[LIMIT_W-1:0];
        default:          limit_nxt = limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready   = 1'b1;
  assign window_limit = limit_r;

endmodule

// ===== hw/rtl/kwfb_engine.sv =====
// ----------------------------------------------------------------------------
// kwfb_engine
// ring store and trim sequencer: append, trigger check, head walk and mark
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwfb_engine
  import kwfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LIMIT_W-1:0] window_limit,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output out_word_t          res
);

  // sequencer and ring pointers
  eng_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    kt_r, kt_nxt;

  // per-word working registers
  in_word_t            item_r, item_nxt;
  logic                was_empty_r, was_empty_nxt;
  logic                appended_r, appended_nxt;
  logic                full_r, full_nxt;
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    scan_i_r, scan_i_nxt;
  logic [CNT_W-1:0]    old_keys_r, old_keys_nxt;
  logic [CNT_W-1:0]    last_old_i_r, last_old_i_nxt;
  logic [IDX_W-1:0]    last_old_ptr_r, last_old_ptr_nxt;
  logic [HANDLE_W-1:0] last_old_handle_r, last_old_handle_nxt;
  logic [HANDLE_W-1:0] head0_handle_r, head0_handle_nxt;
  out_word_t           res_r, res_nxt;

  // memory port
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  slot_t               wr_slot;
  logic [IDX_W-1:0]    rd_addr;
  logic [$bits(slot_t)-1:0] rd_raw;
  slot_t               rd_slot;

  // decision terms
  logic                enabled;
  logic                count_mode;
  logic                ring_full;
  logic signed [DIFF_W-1:0] stamp_diff;
  logic signed [DIFF_W-1:0] limit_ext;
  logic                stamp_old;
  logic                slot_key;
  logic [CNT_W-1:0]    kt_left;
  logic                trigger;
  logic                keep;
  logic [CNT_W-1:0]    drop_n;
  logic [CNT_W-1:0]    kt_new;
  logic [IDX_W-1:0]    new_head;
  logic [HANDLE_W-1:0] new_head_hnd;
  logic [HANDLE_W-1:0] cur_head_hnd;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  kwfb_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_slot = slot_t'(rd_raw);

  // mode and occupancy terms
  assign enabled    = (window_limit != '0);
  assign count_mode = (window_limit < COUNT_MODE_BOUND);
  assign ring_full  = (occ_r == CNT_W'(RING_DEPTH));

  // age of the slot just read against the new word, exact 49-bit difference
  assign stamp_diff = $signed({item_r.decode_stamp[STAMP_W-1], item_r.decode_stamp})
                    - $signed({rd_slot.stamp[STAMP_W-1], rd_slot.stamp});
  assign limit_ext  = $signed({{(DIFF_W-LIMIT_W){1'b0}}, window_limit});
  assign stamp_old  = (stamp_diff > limit_ext);

  // trim trigger, evaluated with the head slot on the read port
  assign trigger = appended_r && !was_empty_r && item_r.is_keyframe &&
                   ((count_mode && (LIMIT_W'(kt_r) > window_limit)) || stamp_old);

  // walk decision for the slot on the read port
  assign slot_key     = rd_slot.flags[FLAG_KEY];
  assign kt_left      = kt_r - old_keys_r;
  assign cur_head_hnd = (scan_i_r == '0) ? rd_slot.handle : head0_handle_r;

  always_comb begin
    if (count_mode) begin
      keep         = slot_key && (LIMIT_W'(kt_left) <= window_limit);
      drop_n       = scan_i_r;
      kt_new       = kt_left;
      new_head     = ptr_r;
      new_head_hnd = rd_slot.handle;
    end else begin
      keep = slot_key && !stamp_old;
      if (old_keys_r != '0) begin
        drop_n       = last_old_i_r;
        kt_new       = kt_left + CNT_W'(1);
        new_head     = last_old_ptr_r;
        new_head_hnd = last_old_handle_r;
      end else begin
        drop_n       = '0;
        kt_new       = kt_r;
        new_head     = head_r;
        new_head_hnd = cur_head_hnd;
      end
    end
  end

  // sequencer next state and memory control
  always_comb begin
    state_nxt           = state_r;
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    occ_nxt             = occ_r;
    kt_nxt              = kt_r;
    item_nxt            = item_r;
    was_empty_nxt       = was_empty_r;
    appended_nxt        = appended_r;
    full_nxt            = full_r;
    ptr_nxt             = ptr_r;
    scan_i_nxt          = scan_i_r;
    old_keys_nxt        = old_keys_r;
    last_old_i_nxt      = last_old_i_r;
    last_old_ptr_nxt    = last_old_ptr_r;
    last_old_handle_nxt = last_old_handle_r;
    head0_handle_nxt    = head0_handle_r;
    res_nxt             = res_r;
    wr_en               = 1'b0;
    wr_addr             = tail_r;
    wr_slot             = rd_slot;
    rd_addr             = head_r;
    in_stall            = 1'b1;
    res_valid           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = head_r;
        if (in_valid) begin
          item_nxt      = in_data;
          was_empty_nxt = (occ_r == '0);
          appended_nxt  = enabled && !ring_full;
          full_nxt      = enabled && ring_full;
          // append at the tail
          if (enabled && !ring_full) begin
            wr_en                   = 1'b1;
            wr_addr                 = tail_r;
            wr_slot.handle          = in_data.frame_handle;
            wr_slot.stamp           = in_data.decode_stamp;
            wr_slot.flags           = '0;
            wr_slot.flags[FLAG_KEY] = in_data.is_keyframe;
            tail_nxt                = ring_next(tail_r);
            occ_nxt                 = occ_r + CNT_W'(1);
            if (in_data.is_keyframe) begin
              kt_nxt = kt_r + CNT_W'(1);
            end
          end
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (trigger) begin
          ptr_nxt      = head_r;
          scan_i_nxt   = '0;
          old_keys_nxt = '0;
          state_nxt    = ST_SCAN_RD;
        end else begin
          res_nxt.accepted      = appended_r;
          res_nxt.ring_full     = full_r;
          res_nxt.dropped_count = '0;
          res_nxt.marked_valid  = 1'b0;
          res_nxt.marked_handle = '0;
          if (occ_r == '0) begin
            res_nxt.head_handle = '0;
          end else if (was_empty_r) begin
            res_nxt.head_handle = item_r.frame_handle;
          end else begin
            res_nxt.head_handle = rd_slot.handle;
          end
          res_nxt.frames_held    = COUNT_W'(occ_r);
          res_nxt.keyframes_held = COUNT_W'(kt_r);
          state_nxt              = ST_DONE;
        end
      end

      ST_SCAN_RD: begin
        rd_addr   = ptr_r;
        state_nxt = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        if (scan_i_r == '0) begin
          head0_handle_nxt = rd_slot.handle;
        end
        if (keep) begin
          // mark the first kept keyframe and retire the dropped head run
          wr_en                    = 1'b1;
          wr_addr                  = ptr_r;
          wr_slot                  = rd_slot;
          wr_slot.flags[FLAG_MARK] = 1'b1;
          head_nxt                 = new_head;
          occ_nxt                  = occ_r - drop_n;
          kt_nxt                   = kt_new;
          res_nxt.accepted         = 1'b1;
          res_nxt.ring_full        = 1'b0;
          res_nxt.dropped_count    = COUNT_W'(drop_n);
          res_nxt.marked_valid     = 1'b1;
          res_nxt.marked_handle    = rd_slot.handle;
          res_nxt.head_handle      = new_head_hnd;
          res_nxt.frames_held      = COUNT_W'(occ_r - drop_n);
          res_nxt.keyframes_held   = COUNT_W'(kt_new);
          state_nxt                = ST_DONE;
        end else begin
          if (slot_key) begin
            old_keys_nxt        = old_keys_r + CNT_W'(1);
            last_old_i_nxt      = scan_i_r;
            last_old_ptr_nxt    = ptr_r;
            last_old_handle_nxt = rd_slot.handle;
          end
          ptr_nxt    = ring_next(ptr_r);
          scan_i_nxt = scan_i_r + CNT_W'(1);
          state_nxt  = ST_SCAN_RD;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      kt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      kt_r    <= kt_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    item_r            <= item_nxt;
    was_empty_r       <= was_empty_nxt;
    appended_r        <= appended_nxt;
    full_r            <= full_nxt;
    ptr_r             <= ptr_nxt;
    scan_i_r          <= scan_i_nxt;
    old_keys_r        <= old_keys_nxt;
    last_old_i_r      <= last_old_i_nxt;
    last_old_ptr_r    <= last_old_ptr_nxt;
    last_old_handle_r <= last_old_handle_nxt;
    head0_handle_r    <= head0_handle_nxt;
    res_r             <= res_nxt;
  end

  assign res = res_r;

endmodule
